### rtl/mcs_pkg.sv
// package: shared types, codes and constants of the microprogrammed cpu step block
`timescale 1ns / 1ps
`default_nettype none
package mcs_pkg;

	localparam int CS_DEPTH_DEF  = 256;
	localparam int MEM_WORDS_DEF = 4096;
	localparam int NUM_REGS_DEF  = 16;
	localparam int MW_W          = 36;

	typedef enum logic [1:0] {
		FN_LD_CS  = 2'd0,
		FN_LD_MEM = 2'd1,
		FN_RUN    = 2'd2,
		FN_START  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_FETCH = 2'd0,
		PH_EXEC  = 2'd1,
		PH_WAIT  = 2'd2,
		PH_MEM   = 2'd3
	} phase_t;

	// alu ops
	localparam logic [3:0] OP_PASS_S = 4'd1;
	localparam logic [3:0] OP_PASS_D = 4'd2;
	localparam logic [3:0] OP_ADD    = 4'd3;
	localparam logic [3:0] OP_SUB    = 4'd4;
	localparam logic [3:0] OP_AND    = 4'd5;
	localparam logic [3:0] OP_OR     = 4'd6;
	localparam logic [3:0] OP_XOR    = 4'd7;
	localparam logic [3:0] OP_ASL    = 4'd8;
	localparam logic [3:0] OP_ASR    = 4'd9;
	localparam logic [3:0] OP_LSR    = 4'd10;
	localparam logic [3:0] OP_ROL    = 4'd11;
	localparam logic [3:0] OP_ROR    = 4'd12;

	// d bus sources
	localparam logic [3:0] DS_FLAGS = 4'd1;
	localparam logic [3:0] DS_REG   = 4'd2;
	localparam logic [3:0] DS_SP    = 4'd3;
	localparam logic [3:0] DS_TMP   = 4'd4;
	localparam logic [3:0] DS_PC    = 4'd5;
	localparam logic [3:0] DS_AR    = 4'd7;
	localparam logic [3:0] DS_MDR   = 4'd8;
	localparam logic [3:0] DS_NMDR  = 4'd9;
	localparam logic [3:0] DS_IRLO  = 4'd10;
	localparam logic [3:0] DS_ZERO  = 4'd11;
	localparam logic [3:0] DS_ONES  = 4'd12;

	// s bus sources
	localparam logic [3:0] SS_FLAGS = 4'd1;
	localparam logic [3:0] SS_REG   = 4'd2;
	localparam logic [3:0] SS_SP    = 4'd3;
	localparam logic [3:0] SS_TMP   = 4'd4;
	localparam logic [3:0] SS_NTMP  = 4'd5;
	localparam logic [3:0] SS_PC    = 4'd6;
	localparam logic [3:0] SS_AR    = 4'd8;
	localparam logic [3:0] SS_MDR   = 4'd9;
	localparam logic [3:0] SS_IRLO  = 4'd10;
	localparam logic [3:0] SS_ZERO  = 4'd11;
	localparam logic [3:0] SS_ONES  = 4'd12;

	// destinations
	localparam logic [3:0] DT_FLAGS1 = 4'd1;
	localparam logic [3:0] DT_FLAGS2 = 4'd2;
	localparam logic [3:0] DT_REG    = 4'd3;
	localparam logic [3:0] DT_SP     = 4'd4;
	localparam logic [3:0] DT_TMP    = 4'd5;
	localparam logic [3:0] DT_PC     = 4'd6;
	localparam logic [3:0] DT_AR     = 4'd8;
	localparam logic [3:0] DT_MDR    = 4'd9;

	// side actions
	localparam logic [3:0] SA_SP_INC  = 4'd1;
	localparam logic [3:0] SA_SP_DEC  = 4'd2;
	localparam logic [3:0] SA_PC_INC  = 4'd3;
	localparam logic [3:0] SA_SET_BE0 = 4'd4;
	localparam logic [3:0] SA_SET_BE1 = 4'd5;
	localparam logic [3:0] SA_LATCH   = 4'd6;
	localparam logic [3:0] SA_LATCH_C = 4'd7;
	localparam logic [3:0] SA_LATCH_ZV = 4'd8;
	localparam logic [3:0] SA_SET_BVI = 4'd9;
	localparam logic [3:0] SA_CLR_BVI = 4'd10;
	localparam logic [3:0] SA_HALT    = 4'd11;
	localparam logic [3:0] SA_CLR_BE  = 4'd13;

	// successor modes
	localparam logic [2:0] NM_ALWAYS = 3'd1;
	localparam logic [2:0] NM_BE0    = 3'd2;
	localparam logic [2:0] NM_BE1    = 3'd3;
	localparam logic [2:0] NM_C      = 3'd4;
	localparam logic [2:0] NM_Z      = 3'd5;
	localparam logic [2:0] NM_N      = 3'd6;
	localparam logic [2:0] NM_V      = 3'd7;

	// memory ops
	localparam logic [1:0] MO_NONE  = 2'd0;
	localparam logic [1:0] MO_LD_IR = 2'd1;
	localparam logic [1:0] MO_LD_MD = 2'd2;
	localparam logic [1:0] MO_STORE = 2'd3;

	typedef struct packed {
		logic [15:0] r;
		logic [3:0]  flags;
	} alu_res_t;

endpackage
`default_nettype wire

### rtl/mcs_ram.sv
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
`default_nettype none
module mcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdata <= '0;
		end else if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/mcs_alu.sv
// 16-bit alu with nzvc flag generation
`timescale 1ns / 1ps
`default_nettype none
module mcs_alu (
	input  wire logic [3:0]  op,
	input  wire logic [15:0] d,
	input  wire logic [15:0] s,
	input  wire logic [15:0] rbus_old,
	output mcs_pkg::alu_res_t res
);
	import mcs_pkg::*;

	logic [16:0] raw;
	logic [31:0] dd;
	logic [31:0] rot_l;
	logic [31:0] rot_r;
	logic [3:0]  asr_sh;
	logic        big;

	always_comb begin
		dd     = {d, d};
		big    = (s[15:4] != 12'd0);
		rot_l  = dd << s[3:0];
		rot_r  = dd >> s[3:0];
		asr_sh = big ? 4'd15 : s[3:0];
		case (op)
			OP_PASS_S: raw = {1'b0, s};
			OP_PASS_D: raw = {1'b0, d};
			OP_ADD:    raw = {1'b0, d} + {1'b0, s};
			OP_SUB:    raw = {1'b0, d} - {1'b0, s};
			OP_AND:    raw = {1'b0, d & s};
			OP_OR:     raw = {1'b0, d | s};
			OP_XOR:    raw = {1'b0, d ^ s};
			OP_ASL:    raw = big ? 17'd0 : {1'b0, d << s[3:0]};
			OP_ASR:    raw = {1'b0, 16'($signed(d) >>> asr_sh)};
			OP_LSR:    raw = big ? 17'd0 : {1'b0, d >> s[3:0]};
			OP_ROL:    raw = {1'b0, rot_l[31:16]};
			OP_ROR:    raw = {1'b0, rot_r[15:0]};
			default:   raw = {1'b0, rbus_old};
		endcase
		res.r        = raw[15:0];
		res.flags[2] = (raw[15:0] == 16'd0);
		res.flags[3] = (raw[15:0] != 16'd0) && raw[15];
		res.flags[1] = raw[15] ^ rbus_old[15];
		res.flags[0] = raw[16];
	end
endmodule
`default_nettype wire

### rtl/microprogrammed_cpu_step_top.sv
// top level: microprogrammed 16-bit cpu, one request per micro-phase
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                       | direction
// in      | in_valid in_stall func address data | request in
// out     | out_valid out_stall micro_address phase running
//         |   program_counter cond_flags result_bus | result out
// a new request is taken every clock unless the
// result register is full and stalled. store reads use the registered read
// port of each ram; the read word is used from the next cycle on.
// reset clears all machine state; both rams are undefined until written.
// out_stall holds the result and stalls the input side in the same cycle.
module microprogrammed_cpu_step_top #(
	parameter int CS_DEPTH  = mcs_pkg::CS_DEPTH_DEF,
	parameter int MEM_WORDS = mcs_pkg::MEM_WORDS_DEF,
	parameter int NUM_REGS  = mcs_pkg::NUM_REGS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] address,
	input  wire logic [35:0] data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       micro_address,
	output logic [1:0]       phase,
	output logic             running,
	output logic [15:0]      program_counter,
	output logic [3:0]       cond_flags,
	output logic [15:0]      result_bus
);
	import mcs_pkg::*;

	localparam int CS_AW = $clog2(CS_DEPTH);
	localparam int MM_AW = $clog2(MEM_WORDS);
	localparam int RF_AW = $clog2(NUM_REGS);

	logic              out_valid_q;
	logic              acc;
	logic [15:0]       regs_q [NUM_REGS];
	logic [15:0]       sp_q, tmp_q, pc_q, ar_q, mdr_q, ir_q, fw_q;
	logic [15:0]       dbus_q, sbus_q, rbus_q;
	logic [3:0]        cc_q;
	logic              be0_q, be1_q, bvi_q, run_q;
	logic [CS_AW-1:0]  mpc_q;
	phase_t            ph_q;
	logic              ld_ir_q, ld_mdr_q;

	logic [15:0]       sp_n, tmp_n, pc_n, ar_n, mdr_n, ir_n, fw_n;
	logic [15:0]       dbus_n, sbus_n, rbus_n;
	logic [3:0]        cc_n;
	logic              be0_n, be1_n, bvi_n, run_n;
	logic [CS_AW-1:0]  mpc_n;
	phase_t            ph_n;
	logic              ld_ir_n, ld_mdr_n;

	logic [MW_W-1:0]   mw;
	logic [15:0]       mm_rd;
	logic [15:0]       ir_e, mdr_e;
	logic              do_run, exec, memph;
	logic [3:0]        d_sel, s_sel, op, dst, sa;
	logic [1:0]        mop;
	logic [2:0]        nmode, imode;
	alu_res_t          ares;
	logic              rf_we;
	logic [RF_AW-1:0]  rf_d_idx, rf_s_idx;
	logic [1:0]        iclass;
	logic [5:0]        idx;
	logic              cond, inv;
	logic [10:0]       jsum;
	logic              cs_we, cs_re, mm_we, mm_re;
	logic [MM_AW-1:0]  mm_waddr;
	logic [15:0]       mm_wdata;

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	assign out_valid       = out_valid_q;
	assign micro_address   = 8'(mpc_q);
	assign phase           = ph_q;
	assign running         = run_q;
	assign program_counter = pc_q;
	assign cond_flags      = cc_q;
	assign result_bus      = rbus_q;

	// memory read data stands in for ir or mdr in the cycle after the load
	assign ir_e  = ld_ir_q ? mm_rd : ir_q;
	assign mdr_e = ld_mdr_q ? mm_rd : mdr_q;

	assign do_run = acc && (func == FN_RUN) && run_q;
	assign exec   = do_run && (ph_q == PH_EXEC);
	assign memph  = do_run && (ph_q == PH_MEM);

	assign d_sel = mw[35:32];
	assign s_sel = mw[31:28];
	assign op    = mw[27:24];
	assign dst   = mw[23:20];
	assign mop   = mw[19:18];
	assign sa    = mw[17:14];
	assign nmode = mw[13:11];
	assign imode = mw[10:8];

	assign rf_d_idx = ir_e[RF_AW-1:0];
	assign rf_s_idx = ir_e[6 +: RF_AW];

	assign cs_we = acc && (func == FN_LD_CS);
	assign cs_re = do_run && (ph_q == PH_FETCH);

	mcs_ram #(.WIDTH(MW_W), .DEPTH(CS_DEPTH)) u_cs (
		.clk(clk), .arst_n(arst_n),
		.we(cs_we), .waddr(address[CS_AW-1:0]), .wdata(data),
		.re(cs_re), .raddr(mpc_q), .rdata(mw)
	);

	assign mm_re    = memph && ((mop == MO_LD_IR) || (mop == MO_LD_MD));
	assign mm_we    = (acc && (func == FN_LD_MEM)) || (memph && (mop == MO_STORE));
	assign mm_waddr = memph ? ar_q[MM_AW-1:0] : address[MM_AW-1:0];
	assign mm_wdata = memph ? mdr_e : data[15:0];

	mcs_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mm (
		.clk(clk), .arst_n(arst_n),
		.we(mm_we), .waddr(mm_waddr), .wdata(mm_wdata),
		.re(mm_re), .raddr(ar_q[MM_AW-1:0]), .rdata(mm_rd)
	);

	// bus sources
	always_comb begin
		case (d_sel)
			DS_FLAGS: dbus_n = fw_q;
			DS_REG:   dbus_n = regs_q[rf_d_idx];
			DS_SP:    dbus_n = sp_q;
			DS_TMP:   dbus_n = tmp_q;
			DS_PC:    dbus_n = pc_q;
			DS_AR:    dbus_n = ar_q;
			DS_MDR:   dbus_n = mdr_e;
			DS_NMDR:  dbus_n = ~mdr_e;
			DS_IRLO:  dbus_n = {8'd0, ir_e[7:0]};
			DS_ZERO:  dbus_n = 16'd0;
			DS_ONES:  dbus_n = 16'hFFFF;
			default:  dbus_n = dbus_q;
		endcase
		case (s_sel)
			SS_FLAGS: sbus_n = fw_q;
			SS_REG:   sbus_n = regs_q[rf_s_idx];
			SS_SP:    sbus_n = sp_q;
			SS_TMP:   sbus_n = tmp_q;
			SS_NTMP:  sbus_n = ~tmp_q;
			SS_PC:    sbus_n = pc_q;
			SS_AR:    sbus_n = ar_q;
			SS_MDR:   sbus_n = mdr_e;
			SS_IRLO:  sbus_n = {8'd0, ir_e[7:0]};
			SS_ZERO:  sbus_n = 16'd0;
			SS_ONES:  sbus_n = 16'hFFFF;
			default:  sbus_n = sbus_q;
		endcase
	end

	mcs_alu u_alu (
		.op(op), .d(dbus_n), .s(sbus_n), .rbus_old(rbus_q), .res(ares)
	);

	// instruction class and jump index from ir fields
	always_comb begin
		if (!ir_e[15]) begin
			iclass = 2'd0;
		end else if (ir_e[15:13] == 3'b111) begin
			iclass = 2'd3;
		end else if (ir_e[15:14] == 2'b11) begin
			iclass = 2'd2;
		end else begin
			iclass = 2'd1;
		end
		case (imode)
			3'd1:    idx = {4'd0, iclass};
			3'd2:    idx = {4'd0, ir_e[11:10]};
			3'd3:    idx = {4'd0, ir_e[5:4]};
			3'd4:    idx = {3'd0, ir_e[14:12]};
			3'd5:    idx = {2'd0, ir_e[9:6]};
			3'd6:    idx = (iclass == 2'd2) ? {1'b0, ir_e[11:8], 1'b0} : {ir_e[4:0], 1'b0};
			default: idx = 6'd0;
		endcase
	end

	// start request, phase sequencing and, in the execute phase: destination write, side action, successor
	always_comb begin
		sp_n     = sp_q;
		tmp_n    = tmp_q;
		pc_n     = pc_q;
		ar_n     = ar_q;
		mdr_n    = mdr_e;
		ir_n     = ir_e;
		fw_n     = fw_q;
		rbus_n   = rbus_q;
		cc_n     = cc_q;
		be0_n    = be0_q;
		be1_n    = be1_q;
		bvi_n    = bvi_q;
		run_n    = run_q;
		mpc_n    = mpc_q;
		ph_n     = ph_q;
		ld_ir_n  = 1'b0;
		ld_mdr_n = 1'b0;
		rf_we    = 1'b0;
		cond     = 1'b0;
		inv      = 1'b0;
		jsum     = 11'(mw[6:0]) + 11'(idx);
		if (acc && (func == FN_START)) begin
			mpc_n = address[CS_AW-1:0];
			ph_n  = PH_FETCH;
			run_n = 1'b1;
		end
		if (do_run) begin
			case (ph_q)
				PH_FETCH: ph_n = PH_EXEC;
				PH_WAIT:  ph_n = PH_MEM;
				PH_MEM: begin
					ph_n     = PH_FETCH;
					ld_ir_n  = (mop == MO_LD_IR);
					ld_mdr_n = (mop == MO_LD_MD);
				end
				default: begin
					rbus_n = ares.r;
					fw_n   = {12'd0, ares.flags};
					case (dst)
						DT_FLAGS1, DT_FLAGS2: fw_n  = ares.r;
						DT_REG:               rf_we = 1'b1;
						DT_SP:                sp_n  = ares.r;
						DT_TMP:               tmp_n = ares.r;
						DT_PC:                pc_n  = ares.r;
						DT_AR:                ar_n  = ares.r;
						DT_MDR:               mdr_n = ares.r;
						default:              ;
					endcase
					case (sa)
						SA_SP_INC:  sp_n  = sp_n + 16'd1;
						SA_SP_DEC:  sp_n  = sp_n - 16'd1;
						SA_PC_INC:  pc_n  = pc_n + 16'd1;
						SA_SET_BE0: be0_n = 1'b1;
						SA_SET_BE1: be1_n = 1'b1;
						SA_LATCH:   cc_n  = fw_n[3:0];
						SA_LATCH_C: begin
							cc_n = fw_n[3:0];
							fw_n = fw_n | 16'd1;
						end
						SA_LATCH_ZV: cc_n = (cc_q & 4'b1001) | (fw_n[3:0] & 4'b0110);
						SA_SET_BVI:  bvi_n = 1'b1;
						SA_CLR_BVI:  bvi_n = 1'b0;
						SA_HALT:     run_n = 1'b0;
						SA_CLR_BE: begin
							be0_n = 1'b0;
							be1_n = 1'b0;
						end
						default: ;
					endcase
					inv = mw[7];
					case (nmode)
						NM_ALWAYS: begin
							cond = 1'b1;
							inv  = 1'b0;
						end
						NM_BE0: cond = be0_n;
						NM_BE1: cond = be1_n;
						NM_C:   cond = fw_n[0];
						NM_Z:   cond = fw_n[2];
						NM_N:   cond = fw_n[3];
						NM_V:   cond = fw_n[1];
						default: begin
							cond = 1'b0;
							inv  = 1'b0;
						end
					endcase
					if (cond != inv) begin
						// jump sum is at most 189, below twice the store depth when that is 95 or more
						if (jsum >= 11'(CS_DEPTH)) begin
							mpc_n = CS_AW'(jsum - 11'(CS_DEPTH));
						end else begin
							mpc_n = CS_AW'(jsum);
						end
					end else if (mpc_q == CS_AW'(CS_DEPTH - 1)) begin
						mpc_n = '0;
					end else begin
						mpc_n = mpc_q + 1'b1;
					end
					ph_n = (mop != MO_NONE) ? PH_WAIT : PH_FETCH;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			sp_q     <= '0;
			tmp_q    <= '0;
			pc_q     <= '0;
			ar_q     <= '0;
			mdr_q    <= '0;
			ir_q     <= '0;
			fw_q     <= '0;
			dbus_q   <= '0;
			sbus_q   <= '0;
			rbus_q   <= '0;
			cc_q     <= '0;
			be0_q    <= 1'b0;
			be1_q    <= 1'b0;
			bvi_q    <= 1'b0;
			run_q    <= 1'b0;
			mpc_q    <= '0;
			ph_q     <= PH_FETCH;
			ld_ir_q  <= 1'b0;
			ld_mdr_q <= 1'b0;
		end else begin
			out_valid_q <= acc || (out_valid_q && out_stall);
			if (rf_we) begin
				regs_q[rf_d_idx] <= ares.r;
			end
			if (exec) begin
				dbus_q <= dbus_n;
				sbus_q <= sbus_n;
			end
			sp_q     <= sp_n;
			tmp_q    <= tmp_n;
			pc_q     <= pc_n;
			ar_q     <= ar_n;
			mdr_q    <= mdr_n;
			ir_q     <= ir_n;
			fw_q     <= fw_n;
			rbus_q   <= rbus_n;
			cc_q     <= cc_n;
			be0_q    <= be0_n;
			be1_q    <= be1_n;
			bvi_q    <= bvi_n;
			run_q    <= run_n;
			mpc_q    <= mpc_n;
			ph_q     <= ph_n;
			ld_ir_q  <= ld_ir_n;
			ld_mdr_q <= ld_mdr_n;
		end
	end

	a_stall_needs_result : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with no result waiting");

	a_accept_gives_result : assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid_q)
		else $error("accepted request produced no result");

	a_halted_phase_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(!run_q && !(acc && (func == FN_START))) |=> $stable(ph_q))
		else $error("phase moved while halted");

	a_load_after_mem : assert property (@(posedge clk) disable iff (!arst_n)
		(ld_ir_q || ld_mdr_q) |-> ($past(ph_q) == PH_MEM))
		else $error("memory load pending outside memory phase");

	a_one_load : assert property (@(posedge clk) disable iff (!arst_n)
		!(ld_ir_q && ld_mdr_q))
		else $error("ir and mdr loads pending together");

endmodule
`default_nettype wire

### verif/tb_top.sv
// testbench: microprogrammed cpu step block against a request-level machine predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import mcs_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1700;
	localparam logic [2:0] IX_CLASS = 3'd1;
	localparam logic [2:0] IX_B11   = 3'd2;
	localparam logic [2:0] IX_B5    = 3'd3;
	localparam logic [2:0] IX_B14   = 3'd4;
	localparam logic [2:0] IX_REGS  = 3'd5;
	localparam logic [2:0] IX_JUMP  = 3'd6;

	typedef struct packed {
		logic [7:0]  upc;
		logic [1:0]  ph;
		logic        run;
		logic [15:0] pc;
		logic [3:0]  cc;
		logic [15:0] rb;
	} machine_view_t;

	class cpu_scoreboard;
		logic [35:0] cs[256];
		bit          cs_wr[256];
		logic [15:0] mem[4096];
		bit          mem_wr[4096];
		logic [15:0] gr[16];
		logic [7:0]  upc;
		logic [35:0] mw;
		phase_t      ph;
		logic [15:0] sp, tmp, pc, ar, mdr, ir, fw, dbus, sbus, rbus;
		logic [3:0]  cc;
		bit          be0, be1, bvi, run;
		machine_view_t expected_states[$];
		int          errors;

		function new();
			foreach (gr[i]) gr[i] = '0;
			foreach (cs_wr[i]) cs_wr[i] = 0;
			foreach (mem_wr[i]) mem_wr[i] = 0;
			upc = '0; mw = '0; ph = PH_FETCH;
			sp = '0; tmp = '0; pc = '0; ar = '0; mdr = '0; ir = '0; fw = '0;
			dbus = '0; sbus = '0; rbus = '0; cc = '0;
			be0 = 0; be1 = 0; bvi = 0; run = 0; errors = 0;
		endfunction

		function logic [15:0] d_source(logic [3:0] sel);
			case (sel)
			DS_FLAGS: return fw;
			DS_REG:   return gr[ir[3:0]];
			DS_SP:    return sp;
			DS_TMP:   return tmp;
			DS_PC:    return pc;
			DS_AR:    return ar;
			DS_MDR:   return mdr;
			DS_NMDR:  return ~mdr;
			DS_IRLO:  return {8'h00, ir[7:0]};
			DS_ZERO:  return 16'h0000;
			DS_ONES:  return 16'hFFFF;
			default:  return dbus;
			endcase
		endfunction

		function logic [15:0] s_source(logic [3:0] sel);
			case (sel)
			SS_FLAGS: return fw;
			SS_REG:   return gr[ir[9:6]];
			SS_SP:    return sp;
			SS_TMP:   return tmp;
			SS_NTMP:  return ~tmp;
			SS_PC:    return pc;
			SS_AR:    return ar;
			SS_MDR:   return mdr;
			SS_IRLO:  return {8'h00, ir[7:0]};
			SS_ZERO:  return 16'h0000;
			SS_ONES:  return 16'hFFFF;
			default:  return sbus;
			endcase
		endfunction

		function void do_alu(logic [3:0] op);
			logic [16:0] raw;
			logic [15:0] d, s;
			logic [3:0]  r;
			logic        old_sign;
			d = dbus; s = sbus; r = sbus[3:0]; old_sign = rbus[15];
			case (op)
			OP_PASS_S: raw = {1'b0, s};
			OP_PASS_D: raw = {1'b0, d};
			OP_ADD:    raw = {1'b0, d} + {1'b0, s};
			OP_SUB:    raw = {1'b0, d} - {1'b0, s};
			OP_AND:    raw = {1'b0, d & s};
			OP_OR:     raw = {1'b0, d | s};
			OP_XOR:    raw = {1'b0, d ^ s};
			OP_ASL:    raw = (s < 16) ? {1'b0, d << r} : 17'd0;
			OP_ASR:    raw = (s < 16) ? {1'b0, 16'($signed(d) >>> r)} : {1'b0, {16{d[15]}}};
			OP_LSR:    raw = (s < 16) ? {1'b0, d >> r} : 17'd0;
			OP_ROL:    raw = {1'b0, 16'((d << r) | (d >> (5'd16 - r)))};
			OP_ROR:    raw = {1'b0, 16'((d >> r) | (d << (5'd16 - r)))};
			default:   raw = {1'b0, rbus};
			endcase
			rbus = raw[15:0];
			fw = '0;
			if (rbus == 0) fw = 16'd4;
			else if (rbus[15]) fw = 16'd8;
			if (raw[16]) fw[0] = 1'b1;
			if (rbus[15] != old_sign) fw[1] = 1'b1;
		endfunction

		function void do_dest(logic [3:0] sel);
			case (sel)
			DT_FLAGS1, DT_FLAGS2: fw = rbus;
			DT_REG: gr[ir[3:0]] = rbus;
			DT_SP:  sp = rbus;
			DT_TMP: tmp = rbus;
			DT_PC:  pc = rbus;
			DT_AR:  ar = rbus;
			DT_MDR: mdr = rbus;
			default: ;
			endcase
		endfunction

		function void do_side(logic [3:0] sel);
			case (sel)
			SA_SP_INC:   sp = sp + 16'd1;
			SA_SP_DEC:   sp = sp - 16'd1;
			SA_PC_INC:   pc = pc + 16'd1;
			SA_SET_BE0:  be0 = 1;
			SA_SET_BE1:  be1 = 1;
			SA_LATCH:    cc = fw[3:0];
			SA_LATCH_C:  begin cc = fw[3:0]; fw[0] = 1'b1; end
			SA_LATCH_ZV: cc = (cc & 4'b1001) | (fw[3:0] & 4'b0110);
			SA_SET_BVI:  bvi = 1;
			SA_CLR_BVI:  bvi = 0;
			SA_HALT:     run = 0;
			SA_CLR_BE:   begin be0 = 0; be1 = 0; end
			default: ;
			endcase
		endfunction

		function logic [1:0] ir_class();
			if (!ir[15]) return 2'd0;
			if (ir[15:13] == 3'b111) return 2'd3;
			if (ir[15:14] == 2'b11) return 2'd2;
			return 2'd1;
		endfunction

		function logic [7:0] jump_index(logic [2:0] mode);
			case (mode)
			IX_CLASS: return {6'd0, ir_class()};
			IX_B11:   return {6'd0, ir[11:10]};
			IX_B5:    return {6'd0, ir[5:4]};
			IX_B14:   return {5'd0, ir[14:12]};
			IX_REGS:  return {4'd0, ir[9:6]};
			IX_JUMP:  return (ir_class() == 2'd2) ? {3'd0, ir[11:8], 1'b0} : {2'd0, ir[4:0], 1'b0};
			default:  return 8'd0;
			endcase
		endfunction

		function void do_next();
			bit taken, inv;
			inv = mw[7];
			case (mw[13:11])
			NM_ALWAYS: begin taken = 1; inv = 0; end
			NM_BE0: taken = be0;
			NM_BE1: taken = be1;
			NM_C:   taken = fw[0];
			NM_Z:   taken = fw[2];
			NM_N:   taken = fw[3];
			NM_V:   taken = fw[1];
			default: begin taken = 0; inv = 0; end
			endcase
			if (taken != inv) upc = {1'b0, mw[6:0]} + jump_index(mw[10:8]);
			else upc = upc + 8'd1;
		endfunction

		function void advance_machine();
			case (ph)
			PH_FETCH: begin
				mw = cs[upc];
				ph = PH_EXEC;
			end
			PH_EXEC: begin
				dbus = d_source(mw[35:32]);
				sbus = s_source(mw[31:28]);
				do_alu(mw[27:24]);
				do_dest(mw[23:20]);
				do_side(mw[17:14]);
				do_next();
				ph = (mw[19:18] != MO_NONE) ? PH_WAIT : PH_FETCH;
			end
			PH_WAIT: ph = PH_MEM;
			default: begin
				case (mw[19:18])
				MO_LD_IR: ir = mem[ar[11:0]];
				MO_LD_MD: mdr = mem[ar[11:0]];
				MO_STORE: begin mem[ar[11:0]] = mdr; mem_wr[ar[11:0]] = 1; end
				default: ;
				endcase
				ph = PH_FETCH;
			end
			endcase
		endfunction

		function void note_request(logic [1:0] f, logic [15:0] a, logic [35:0] d);
			machine_view_t v;
			case (func_t'(f))
			FN_LD_CS:  begin cs[a[7:0]] = d; cs_wr[a[7:0]] = 1; end
			FN_LD_MEM: begin mem[a[11:0]] = d[15:0]; mem_wr[a[11:0]] = 1; end
			FN_RUN:    if (run) advance_machine();
			default:   begin upc = a[7:0]; ph = PH_FETCH; run = 1; end
			endcase
			v.upc = upc; v.ph = ph; v.run = run; v.pc = pc; v.cc = cc; v.rb = rbus;
			expected_states.push_back(v);
		endfunction

		function void check_result(machine_view_t got);
			machine_view_t e;
			if (expected_states.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			e = expected_states.pop_front();
			if (got.upc !== e.upc) begin
				$error("micro_address expected %0h got %0h", e.upc, got.upc); errors++;
			end
			if (got.ph !== e.ph) begin
				$error("phase expected %0d got %0d", e.ph, got.ph); errors++;
			end
			if (got.run !== e.run) begin
				$error("running expected %0b got %0b", e.run, got.run); errors++;
			end
			if (got.pc !== e.pc) begin
				$error("program_counter expected %0h got %0h", e.pc, got.pc); errors++;
			end
			if (got.cc !== e.cc) begin
				$error("cond_flags expected %0h got %0h", e.cc, got.cc); errors++;
			end
			if (got.rb !== e.rb) begin
				$error("result_bus expected %0h got %0h", e.rb, got.rb); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [15:0] address = '0;
	logic [35:0] data = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [7:0]  micro_address;
	logic [1:0]  phase;
	logic        running;
	logic [15:0] program_counter;
	logic [3:0]  cond_flags;
	logic [15:0] result_bus;

	cpu_scoreboard sb;
	bit quiet = 0;
	int cycles = 0;

	microprogrammed_cpu_step_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .address(address), .data(data),
		.out_valid(out_valid), .out_stall(out_stall),
		.micro_address(micro_address), .phase(phase), .running(running),
		.program_counter(program_counter), .cond_flags(cond_flags),
		.result_bus(result_bus)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({micro_address, phase, running, program_counter,
				cond_flags, result_bus});
	end

	// receiver: random stall bursts plus one long hold-off to back up the block
	initial begin
		int n;
		wait (arst_n);
		repeat (40) @(posedge clk);
		out_stall <= 1;
		repeat (200) @(posedge clk);
		out_stall <= 0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	function logic [35:0] rand_word();
		return {4'($urandom), $urandom};
	endfunction

	task automatic send(logic [1:0] f, logic [15:0] a, logic [35:0] d);
		int n;
		in_valid <= 1;
		func <= f;
		address <= a;
		data <= d;
		do @(posedge clk); while (in_stall);
		sb.note_request(f, a, d);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 13);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	// keeps fetches and memory loads away from never-written entries
	task automatic run_phase_safely();
		logic [11:0] ma;
		ma = sb.ar[11:0];
		if (sb.run && sb.ph == PH_FETCH && !sb.cs_wr[sb.upc])
			send(FN_LD_CS, {8'($urandom_range(0, 255)), sb.upc}, rand_word());
		if (sb.run && sb.ph == PH_MEM && !sb.mem_wr[ma] &&
				(sb.mw[19:18] == MO_LD_IR || sb.mw[19:18] == MO_LD_MD))
			send(FN_LD_MEM, {4'($urandom_range(0, 15)), ma}, rand_word());
		send(FN_RUN, 16'($urandom), rand_word());
	endtask

	initial begin
		int k;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// run while halted changes nothing
		send(FN_RUN, 16'hFFFF, 36'hF_FFFF_FFFF);
		send(FN_LD_CS, 16'hFFFF, 36'h0_0000_0000);
		send(FN_LD_MEM, 16'hFFFF, 36'hF_FFFF_FFFF);
		send(FN_LD_CS, 16'h0000, 36'hF_FFFF_FFFF);
		// add with carry out, latch flags, jump always
		send(FN_LD_CS, 16'h0105, {DS_ONES, SS_ONES, OP_ADD, DT_TMP, MO_NONE, SA_LATCH,
			NM_ALWAYS, IX_CLASS, 1'b0, 7'h7F});
		send(FN_START, 16'h0105, 36'h0);
		run_phase_safely();
		run_phase_safely();
		// all-ones word: unused selects, store, halt-free side code
		send(FN_START, 16'hFF00, 36'h0);
		for (k = 0; k < 6; k++) run_phase_safely();
		send(FN_LD_CS, 16'h0001, {DS_ZERO, SS_ONES, OP_SUB, DT_AR, MO_LD_MD, SA_HALT,
			NM_Z, IX_JUMP, 1'b1, 7'h00});
		send(FN_START, 16'h0001, 36'h0);
		for (k = 0; k < 5; k++) run_phase_safely();
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k > RANDOM_ITEMS - 150) quiet = 1;
			if (!sb.run) begin
				if ($urandom_range(0, 3) != 0) send(FN_START, 16'($urandom), rand_word());
				else if ($urandom_range(0, 1)) send(FN_LD_CS, 16'($urandom), rand_word());
				else send(FN_LD_MEM, 16'($urandom), rand_word());
			end else begin
				case ($urandom_range(0, 19))
				0, 1:    send(FN_LD_CS, 16'($urandom), rand_word());
				2:       send(FN_LD_MEM, 16'($urandom), rand_word());
				3:       send(FN_START, 16'($urandom), rand_word());
				default: run_phase_safely();
				endcase
			end
		end
		in_valid <= 0;
		while (sb.expected_states.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

### microprogrammed_cpu_step_top.f
rtl/mcs_pkg.sv
rtl/mcs_ram.sv
rtl/mcs_alu.sv
rtl/microprogrammed_cpu_step_top.sv
verif/tb_top.sv
